// ===== rtl/ddpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ddpt_pkg: shared types and microcode for the tag tracking drive controller
// Holds the opcode and register index codes, the control word layout, the
// interface structs between sequencer and datapath, and the microcode table.
// ----------------------------------------------------------------------------
`default_nettype none

package ddpt_pkg;

    localparam int DATA_W    = 32;
    localparam int PWM_W     = 18;
    localparam int LIMIT_W   = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int STEP_W    = 4;

    localparam logic [1:0] OPC_VEL  = 2'd0;
    localparam logic [1:0] OPC_TAG  = 2'd1;
    localparam logic [1:0] OPC_TICK = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIN_KP   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIN_KI   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ANG_KP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ANG_KI   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PWM_LIM  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAG_LIN  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAG_ANG  = 3'd7;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [0:0] {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef enum logic [1:0] {
        C_NONE,
        C_MODE0,
        C_FRESH,
        C_RUN
    } cond_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOST,
        OP_ERR_TAG,
        OP_TGT_LIN,
        OP_TGT_ANG,
        OP_STOPPED,
        OP_ERR_VEL,
        OP_INTEG,
        OP_EMIT
    } dop_t;

    typedef enum logic [2:0] {
        M_NONE,
        M_TLIN,
        M_TANG,
        M_LKP,
        M_LKI,
        M_AKP,
        M_AKI
    } msel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SWAP
    } acc_t;

    typedef struct packed {
        cond_t cond;
        step_t target;
        dop_t  op;
        msel_t mul;
        acc_t  acc;
        logic  emit;
        logic  fin;
    } uword_t;

    typedef struct packed {
        logic   active;
        uword_t word;
    } ctrl_t;

    typedef struct packed {
        logic mode0;
        logic fresh;
        logic run;
    } status_t;

    typedef struct packed {
        logic                      mode;
        logic signed [DATA_W-1:0]  lin_kp;
        logic signed [DATA_W-1:0]  lin_ki;
        logic signed [DATA_W-1:0]  ang_kp;
        logic signed [DATA_W-1:0]  ang_ki;
        logic [LIMIT_W-1:0]        pwm_limit;
        logic signed [DATA_W-1:0]  tag_lin_gain;
        logic signed [DATA_W-1:0]  tag_ang_gain;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [DATA_W-1:0]         time_us;
        logic signed [DATA_W-1:0]  cmd_lin;
        logic signed [DATA_W-1:0]  cmd_ang;
        logic                      stop_req;
        logic signed [DATA_W-1:0]  tag_off_x;
        logic signed [DATA_W-1:0]  tag_off_y;
        logic signed [DATA_W-1:0]  tag_goal_x;
        logic signed [DATA_W-1:0]  tag_goal_y;
        logic signed [DATA_W-1:0]  meas_lin;
        logic signed [DATA_W-1:0]  meas_ang;
    } in_t;

    typedef struct packed {
        logic signed [PWM_W-1:0] pwm_right;
        logic signed [PWM_W-1:0] pwm_left;
        logic                    tag_lost;
        logic                    stopped;
    } res_t;

    // Tick program. Tag mode runs the stale check and target update first, then
    // unless the tag is stale both modes share the PI section from the stop check.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        w = '{cond: C_NONE, target: '0, op: OP_NOP, mul: M_NONE,
              acc: ACC_HOLD, emit: 1'b0, fin: 1'b0};
        case (s)
            4'd0: begin
                w.cond = C_MODE0;
                w.target = 4'd7;
            end
            4'd1: begin
                w.cond = C_FRESH;
                w.target = 4'd3;
            end
            4'd2: begin
                w.op = OP_LOST;
                w.emit = 1'b1;
                w.fin = 1'b1;
            end
            4'd3: begin
                w.op = OP_ERR_TAG;
            end
            4'd4: begin
                w.mul = M_TLIN;
            end
            4'd5: begin
                w.op = OP_TGT_LIN;
                w.mul = M_TANG;
            end
            4'd6: begin
                w.op = OP_TGT_ANG;
            end
            4'd7: begin
                w.cond = C_RUN;
                w.target = 4'd9;
            end
            4'd8: begin
                w.op = OP_STOPPED;
                w.emit = 1'b1;
                w.fin = 1'b1;
            end
            4'd9: begin
                w.op = OP_ERR_VEL;
            end
            4'd10: begin
                w.op = OP_INTEG;
                w.mul = M_LKP;
            end
            4'd11: begin
                w.acc = ACC_LOAD;
                w.mul = M_LKI;
            end
            4'd12: begin
                w.acc = ACC_ADD;
                w.mul = M_AKP;
            end
            4'd13: begin
                w.acc = ACC_SWAP;
                w.mul = M_AKI;
            end
            4'd14: begin
                w.acc = ACC_ADD;
            end
            4'd15: begin
                w.op = OP_EMIT;
                w.emit = 1'b1;
                w.fin = 1'b1;
            end
            default: begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ddpt_sequencer.sv =====
// ----------------------------------------------------------------------------
// ddpt_sequencer: microcode step counter
// Walks the tick program one control word per cycle, takes conditional jumps
// on datapath status and holds on a result step while the output is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ddpt_sequencer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic              out_busy,
    input  wire ddpt_pkg::status_t stat,
    output ddpt_pkg::ctrl_t        ctrl,
    output logic                   busy
);

    ddpt_pkg::seq_state_t state_reg, state_next;
    ddpt_pkg::step_t      step_reg, step_next;
    ddpt_pkg::uword_t     word;
    logic                 stall;
    logic                 take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ddpt_pkg::SEQ_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        word  = ddpt_pkg::ucode(step_reg);
        stall = word.emit && out_busy;
        case (word.cond)
            ddpt_pkg::C_MODE0: take = stat.mode0;
            ddpt_pkg::C_FRESH: take = stat.fresh;
            ddpt_pkg::C_RUN:   take = stat.run;
            default:           take = 1'b0;
        endcase

        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ddpt_pkg::SEQ_IDLE: begin
                if (start) begin
                    state_next = ddpt_pkg::SEQ_RUN;
                    step_next  = '0;
                end
            end
            ddpt_pkg::SEQ_RUN: begin
                if (!stall) begin
                    if (take) begin
                        step_next = word.target;
                    end else if (word.fin) begin
                        state_next = ddpt_pkg::SEQ_IDLE;
                    end else begin
                        step_next = step_reg + ddpt_pkg::step_t'(1);
                    end
                end
            end
            default: begin
                state_next = ddpt_pkg::SEQ_IDLE;
            end
        endcase

        ctrl.active = (state_reg == ddpt_pkg::SEQ_RUN) && !stall;
        ctrl.word   = word;
        busy        = (state_reg != ddpt_pkg::SEQ_IDLE);
    end

endmodule

`default_nettype wire

// ===== rtl/ddpt_datapath.sv =====
// ----------------------------------------------------------------------------
// ddpt_datapath: controller state and shared arithmetic
// Holds targets, integrators, tag report and stop flag, and carries out the
// operations named by the control word around one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ddpt_datapath #(
    parameter logic [31:0] LIN_LIMIT      = 32'd65536,
    parameter logic [31:0] ANG_LIMIT      = 32'd131072,
    parameter logic [31:0] DEADBAND_X     = 32'd1311,
    parameter logic [31:0] DEADBAND_Y     = 32'd1311,
    parameter logic [31:0] TAG_TIMEOUT_US = 32'd500000,
    parameter int          FRAC_BITS      = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_acc,
    input  wire ddpt_pkg::in_t   in_item,
    input  wire ddpt_pkg::cfg_t  cfg,
    input  wire ddpt_pkg::ctrl_t ctrl,
    output ddpt_pkg::status_t    stat,
    output ddpt_pkg::res_t       res
);

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    logic signed [31:0] integ_lin_reg, integ_lin_next;
    logic signed [31:0] integ_ang_reg, integ_ang_next;
    logic signed [31:0] tgt_lin_reg, tgt_lin_next;
    logic signed [31:0] tgt_ang_reg, tgt_ang_next;
    logic               stop_reg, stop_next;
    logic signed [31:0] off_x_reg, off_x_next;
    logic signed [31:0] off_y_reg, off_y_next;
    logic signed [31:0] goal_x_reg, goal_x_next;
    logic signed [31:0] goal_y_reg, goal_y_next;
    logic [31:0]        stamp_reg, stamp_next;
    logic [31:0]        now_reg, now_next;
    logic signed [31:0] ml_reg, ml_next;
    logic signed [31:0] ma_reg, ma_next;
    logic signed [31:0] e_lin_reg, e_lin_next;
    logic signed [31:0] e_ang_reg, e_ang_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] ptot_reg, ptot_next;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] fsh;
    logic signed [63:0] mix_sum;
    logic signed [63:0] mix_dif;
    logic signed [63:0] pwm_lim;
    logic [31:0]        age;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? S32_MIN : S32_MAX;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        return sat33(d);
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic logic signed [31:0] dead(input logic signed [31:0] e,
                                                input logic [31:0] band);
        logic [32:0] mag;
        mag = e[31] ? (33'd0 - {e[31], e}) : {1'b0, e};
        return (mag < {1'b0, band}) ? 32'sd0 : e;
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_lin_reg <= '0;
            integ_ang_reg <= '0;
            tgt_lin_reg   <= '0;
            tgt_ang_reg   <= '0;
            stop_reg      <= 1'b0;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            stamp_reg     <= '0;
        end else begin
            integ_lin_reg <= integ_lin_next;
            integ_ang_reg <= integ_ang_next;
            tgt_lin_reg   <= tgt_lin_next;
            tgt_ang_reg   <= tgt_ang_next;
            stop_reg      <= stop_next;
            off_x_reg     <= off_x_next;
            off_y_reg     <= off_y_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            stamp_reg     <= stamp_next;
        end
        now_reg   <= now_next;
        ml_reg    <= ml_next;
        ma_reg    <= ma_next;
        e_lin_reg <= e_lin_next;
        e_ang_reg <= e_ang_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        ptot_reg  <= ptot_next;
    end

    always_comb begin
        fsh     = prod_reg >>> FRAC_BITS;
        age     = now_reg - stamp_reg;
        mix_sum = ptot_reg + acc_reg;
        mix_dif = ptot_reg - acc_reg;
        pwm_lim = $signed({47'd0, cfg.pwm_limit});

        stat.mode0 = !cfg.mode;
        stat.fresh = !(age > TAG_TIMEOUT_US);
        stat.run   = !stop_reg;

        case (ctrl.word.mul)
            ddpt_pkg::M_TLIN: begin
                mul_a = cfg.tag_lin_gain;
                mul_b = e_lin_reg;
            end
            ddpt_pkg::M_TANG: begin
                mul_a = cfg.tag_ang_gain;
                mul_b = e_ang_reg;
            end
            ddpt_pkg::M_LKP: begin
                mul_a = cfg.lin_kp;
                mul_b = e_lin_reg;
            end
            ddpt_pkg::M_LKI: begin
                mul_a = cfg.lin_ki;
                mul_b = integ_lin_reg;
            end
            ddpt_pkg::M_AKP: begin
                mul_a = cfg.ang_kp;
                mul_b = e_ang_reg;
            end
            ddpt_pkg::M_AKI: begin
                mul_a = cfg.ang_ki;
                mul_b = integ_ang_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        integ_lin_next = integ_lin_reg;
        integ_ang_next = integ_ang_reg;
        tgt_lin_next   = tgt_lin_reg;
        tgt_ang_next   = tgt_ang_reg;
        stop_next      = stop_reg;
        off_x_next     = off_x_reg;
        off_y_next     = off_y_reg;
        goal_x_next    = goal_x_reg;
        goal_y_next    = goal_y_reg;
        stamp_next     = stamp_reg;
        now_next       = now_reg;
        ml_next        = ml_reg;
        ma_next        = ma_reg;
        e_lin_next     = e_lin_reg;
        e_ang_next     = e_ang_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        ptot_next      = ptot_reg;

        res.pwm_right = '0;
        res.pwm_left  = '0;
        res.tag_lost  = 1'b0;
        res.stopped   = 1'b0;

        if (in_acc) begin
            case (in_item.opcode)
                ddpt_pkg::OPC_VEL: begin
                    tgt_lin_next = in_item.cmd_lin;
                    tgt_ang_next = in_item.cmd_ang;
                    stop_next    = in_item.stop_req;
                end
                ddpt_pkg::OPC_TAG: begin
                    off_x_next  = in_item.tag_off_x;
                    off_y_next  = in_item.tag_off_y;
                    goal_x_next = in_item.tag_goal_x;
                    goal_y_next = in_item.tag_goal_y;
                    stamp_next  = in_item.time_us;
                end
                ddpt_pkg::OPC_TICK: begin
                    now_next = in_item.time_us;
                    ml_next  = in_item.meas_lin;
                    ma_next  = in_item.meas_ang;
                end
                default: begin
                end
            endcase
        end

        case (ctrl.word.op)
            ddpt_pkg::OP_LOST: begin
                res.tag_lost = 1'b1;
                if (ctrl.active) begin
                    integ_lin_next = '0;
                    integ_ang_next = '0;
                    tgt_lin_next   = '0;
                    tgt_ang_next   = '0;
                end
            end
            ddpt_pkg::OP_ERR_TAG: begin
                if (ctrl.active) begin
                    e_lin_next = dead(sub_sat(off_x_reg, goal_x_reg), DEADBAND_X);
                    e_ang_next = dead(sub_sat(off_y_reg, goal_y_reg), DEADBAND_Y);
                end
            end
            ddpt_pkg::OP_TGT_LIN: begin
                if (ctrl.active) begin
                    tgt_lin_next = 32'(clamp64(fsh, $signed({32'd0, LIN_LIMIT})));
                end
            end
            ddpt_pkg::OP_TGT_ANG: begin
                if (ctrl.active) begin
                    tgt_ang_next = 32'(clamp64(fsh, $signed({32'd0, ANG_LIMIT})));
                end
            end
            ddpt_pkg::OP_STOPPED: begin
                res.stopped = 1'b1;
                if (ctrl.active) begin
                    integ_lin_next = '0;
                    integ_ang_next = '0;
                end
            end
            ddpt_pkg::OP_ERR_VEL: begin
                if (ctrl.active) begin
                    e_lin_next = sub_sat(tgt_lin_reg, ml_reg);
                    e_ang_next = sub_sat(tgt_ang_reg, ma_reg);
                end
            end
            ddpt_pkg::OP_INTEG: begin
                if (ctrl.active) begin
                    integ_lin_next = add_sat(integ_lin_reg, e_lin_reg);
                    integ_ang_next = add_sat(integ_ang_reg, e_ang_reg);
                end
            end
            ddpt_pkg::OP_EMIT: begin
                res.pwm_right = 18'(clamp64(mix_sum >>> 1, pwm_lim));
                res.pwm_left  = 18'(clamp64(mix_dif >>> 1, pwm_lim));
            end
            default: begin
            end
        endcase

        if (ctrl.active && (ctrl.word.mul != ddpt_pkg::M_NONE)) begin
            prod_next = 64'(mul_a) * 64'(mul_b);
        end

        if (ctrl.active) begin
            case (ctrl.word.acc)
                ddpt_pkg::ACC_LOAD: begin
                    acc_next = fsh;
                end
                ddpt_pkg::ACC_ADD: begin
                    acc_next = acc_reg + fsh;
                end
                ddpt_pkg::ACC_SWAP: begin
                    ptot_next = acc_reg;
                    acc_next  = fsh;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/diff_drive_pi_tag_tracker.sv =====
// ----------------------------------------------------------------------------
// diff_drive_pi_tag_tracker: differential drive PI controller with tag tracking
// Velocity commands and tag reports are stored on acceptance. A tick runs the
// microcode program: stop check and PI section in velocity mode, after the stale
// check and target update in tag mode; a stale tag or set stop flag ends it
// early. The result word is registered from the last step, and the next word is
// accepted once the sequencer is idle. A full output register holds the last
// step. Synchronous active-low reset clears configuration to defaults and state.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_pi_tag_tracker #(
    parameter logic [31:0] LIN_LIMIT      = 32'd65536,
    parameter logic [31:0] ANG_LIMIT      = 32'd131072,
    parameter logic [31:0] DEADBAND_X     = 32'd1311,
    parameter logic [31:0] DEADBAND_Y     = 32'd1311,
    parameter logic [31:0] TAG_TIMEOUT_US = 32'd500000,
    parameter int          FRAC_BITS      = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // time_us, cmd_lin, cmd_ang, stop_req, tag_off_x, tag_off_y,
    // tag_goal_x, tag_goal_y, meas_lin, meas_ang, zero fill
    input  wire logic [295:0] s_tdata,
    // opcode
    input  wire logic [1:0]   s_tuser,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pwm_right, pwm_left, tag_lost, stopped, zero fill
    output logic [39:0]       m_tdata,

    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);

    ddpt_pkg::cfg_t    cfg_reg, cfg_next;
    ddpt_pkg::in_t     in_item;
    ddpt_pkg::ctrl_t   ctrl;
    ddpt_pkg::status_t stat;
    ddpt_pkg::res_t    res;
    ddpt_pkg::res_t    m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;
    logic              busy;
    logic              in_acc;
    logic              emit;

    always_comb begin
        in_item.opcode     = s_tuser;
        in_item.time_us    = s_tdata[31:0];
        in_item.cmd_lin    = s_tdata[63:32];
        in_item.cmd_ang    = s_tdata[95:64];
        in_item.stop_req   = s_tdata[96];
        in_item.tag_off_x  = s_tdata[128:97];
        in_item.tag_off_y  = s_tdata[160:129];
        in_item.tag_goal_x = s_tdata[192:161];
        in_item.tag_goal_y = s_tdata[224:193];
        in_item.meas_lin   = s_tdata[256:225];
        in_item.meas_ang   = s_tdata[288:257];
    end

    assign s_tready = !busy;
    assign in_acc   = s_tvalid && s_tready;
    assign emit     = ctrl.active && ctrl.word.emit;

    ddpt_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_acc && (s_tuser == ddpt_pkg::OPC_TICK)),
        .out_busy (m_valid_reg && !m_tready),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    ddpt_datapath #(
        .LIN_LIMIT      (LIN_LIMIT),
        .ANG_LIMIT      (ANG_LIMIT),
        .DEADBAND_X     (DEADBAND_X),
        .DEADBAND_Y     (DEADBAND_Y),
        .TAG_TIMEOUT_US (TAG_TIMEOUT_US),
        .FRAC_BITS      (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_acc  (in_acc),
        .in_item (in_item),
        .cfg     (cfg_reg),
        .ctrl    (ctrl),
        .stat    (stat),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode         <= 1'b0;
            cfg_reg.lin_kp       <= '0;
            cfg_reg.lin_ki       <= '0;
            cfg_reg.ang_kp       <= '0;
            cfg_reg.ang_ki       <= '0;
            cfg_reg.pwm_limit    <= 17'd65536;
            cfg_reg.tag_lin_gain <= '0;
            cfg_reg.tag_ang_gain <= '0;
            m_valid_reg          <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                ddpt_pkg::CFG_MODE:    cfg_next.mode         = cfg_wdata[0];
                ddpt_pkg::CFG_LIN_KP:  cfg_next.lin_kp       = cfg_wdata;
                ddpt_pkg::CFG_LIN_KI:  cfg_next.lin_ki       = cfg_wdata;
                ddpt_pkg::CFG_ANG_KP:  cfg_next.ang_kp       = cfg_wdata;
                ddpt_pkg::CFG_ANG_KI:  cfg_next.ang_ki       = cfg_wdata;
                ddpt_pkg::CFG_PWM_LIM: cfg_next.pwm_limit    = cfg_wdata[16:0];
                ddpt_pkg::CFG_TAG_LIN: cfg_next.tag_lin_gain = cfg_wdata;
                ddpt_pkg::CFG_TAG_ANG: cfg_next.tag_ang_gain = cfg_wdata;
                default: begin
                end
            endcase
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg.stopped, m_data_reg.tag_lost,
                       m_data_reg.pwm_left, m_data_reg.pwm_right};

endmodule

`default_nettype wire

// ===== tb/diff_drive_pi_tag_tracker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_pi_tag_tracker_test: self-checking bench for the tag tracking
// drive controller
// Streams velocity commands, tag reports and control ticks into the block
// under several register settings and idle patterns. A cycle-free model of
// the controller predicts the wheel drive of every tick, and each result word
// is checked against it field by field.
// ----------------------------------------------------------------------------

module diff_drive_pi_tag_tracker_test;

    localparam logic [1:0] OPC_SPARE = 2'd3;
    localparam longint TRK_LIN_LIMIT = 65536;
    localparam longint TRK_ANG_LIMIT = 131072;
    localparam longint TRK_DEADBAND_X = 1311;
    localparam longint TRK_DEADBAND_Y = 1311;
    localparam logic [31:0] TRK_TIMEOUT_US = 32'd500000;
    localparam int TRK_FRAC = 16;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [295:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    diff_drive_pi_tag_tracker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    ddpt_pkg::in_t  pending_words[$];
    ddpt_pkg::res_t drive_expected[$];
    ddpt_pkg::in_t  cur_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int error_count = 0;
    logic [31:0] clock_us = '0;

    bit     track_mode = 1'b0;
    longint gain_lin_p = 0;
    longint gain_lin_i = 0;
    longint gain_ang_p = 0;
    longint gain_ang_i = 0;
    longint drive_limit = 65536;
    longint tag_gain_lin = 0;
    longint tag_gain_ang = 0;

    longint      integ_lin_acc = 0;
    longint      integ_ang_acc = 0;
    longint      tgt_lin = 0;
    longint      tgt_ang = 0;
    bit          stop_latched = 1'b0;
    longint      tag_x = 0;
    longint      tag_y = 0;
    longint      goal_x = 0;
    longint      goal_y = 0;
    logic [31:0] tag_time = '0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint sat_s32(longint x);
        if (x > longint'(Q_MAX)) return longint'(Q_MAX);
        if (x < longint'(Q_MIN)) return longint'(Q_MIN);
        return x;
    endfunction

    function automatic longint clamp_mag(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> TRK_FRAC;
    endfunction

    function automatic longint apply_deadband(longint e, longint band);
        longint m;
        m = (e < 0) ? -e : e;
        return (m < band) ? 0 : e;
    endfunction

    task automatic run_loop(input longint ml, input longint ma, output ddpt_pkg::res_t r);
        longint el, ea, ptot, pdif;
        r = '0;
        if (stop_latched) begin
            integ_lin_acc = 0;
            integ_ang_acc = 0;
            r.stopped = 1'b1;
        end else begin
            el = sat_s32(tgt_lin - ml);
            ea = sat_s32(tgt_ang - ma);
            integ_lin_acc = sat_s32(integ_lin_acc + el);
            integ_ang_acc = sat_s32(integ_ang_acc + ea);
            ptot = qmul(gain_lin_p, el) + qmul(gain_lin_i, integ_lin_acc);
            pdif = qmul(gain_ang_p, ea) + qmul(gain_ang_i, integ_ang_acc);
            r.pwm_right = 18'(clamp_mag((ptot + pdif) >>> 1, drive_limit));
            r.pwm_left = 18'(clamp_mag((ptot - pdif) >>> 1, drive_limit));
        end
    endtask

    task automatic predict_drive(input ddpt_pkg::in_t w);
        ddpt_pkg::res_t r;
        logic [31:0]    age;
        longint         ex, ey;
        case (w.opcode)
            ddpt_pkg::OPC_VEL: begin
                tgt_lin = $signed(w.cmd_lin);
                tgt_ang = $signed(w.cmd_ang);
                stop_latched = w.stop_req;
            end
            ddpt_pkg::OPC_TAG: begin
                tag_x = $signed(w.tag_off_x);
                tag_y = $signed(w.tag_off_y);
                goal_x = $signed(w.tag_goal_x);
                goal_y = $signed(w.tag_goal_y);
                tag_time = w.time_us;
            end
            ddpt_pkg::OPC_TICK: begin
                r = '0;
                age = w.time_us - tag_time;
                if (track_mode && age > TRK_TIMEOUT_US) begin
                    integ_lin_acc = 0;
                    integ_ang_acc = 0;
                    tgt_lin = 0;
                    tgt_ang = 0;
                    r.tag_lost = 1'b1;
                end else begin
                    if (track_mode) begin
                        ex = apply_deadband(sat_s32(tag_x - goal_x), TRK_DEADBAND_X);
                        ey = apply_deadband(sat_s32(tag_y - goal_y), TRK_DEADBAND_Y);
                        tgt_lin = clamp_mag(qmul(tag_gain_lin, ex), TRK_LIN_LIMIT);
                        tgt_ang = clamp_mag(qmul(tag_gain_ang, ey), TRK_ANG_LIMIT);
                    end
                    run_loop($signed(w.meas_lin), $signed(w.meas_ang), r);
                end
                drive_expected.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic [295:0] pack_word(ddpt_pkg::in_t w);
        return {7'd0, w.meas_ang, w.meas_lin, w.tag_goal_y, w.tag_goal_x, w.tag_off_y,
                w.tag_off_x, w.stop_req, w.cmd_ang, w.cmd_lin, w.time_us};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_drive(cur_word);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    s_tdata <= pack_word(cur_word);
                    s_tuser <= cur_word.opcode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_drive(input logic [39:0] data);
        ddpt_pkg::res_t got, want;
        got.pwm_right = data[17:0];
        got.pwm_left = data[35:18];
        got.tag_lost = data[36];
        got.stopped = data[37];
        if (drive_expected.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
                $display("unexpected drive word %h at %0t", data, $realtime);
            end
        end else begin
            want = drive_expected.pop_front();
            if (got.pwm_right !== want.pwm_right || got.pwm_left !== want.pwm_left ||
                got.tag_lost !== want.tag_lost || got.stopped !== want.stopped) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("drive mismatch at %0t, expected/actual: right %0d/%0d",
                             $realtime, want.pwm_right, got.pwm_right);
                    $display("  left %0d/%0d lost %b/%b stopped %b/%b",
                             want.pwm_left, got.pwm_left, want.tag_lost, got.tag_lost,
                             want.stopped, got.stopped);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_drive(m_tdata);
            end
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic set_register(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            ddpt_pkg::CFG_MODE:    track_mode = val[0];
            ddpt_pkg::CFG_LIN_KP:  gain_lin_p = $signed(val);
            ddpt_pkg::CFG_LIN_KI:  gain_lin_i = $signed(val);
            ddpt_pkg::CFG_ANG_KP:  gain_ang_p = $signed(val);
            ddpt_pkg::CFG_ANG_KI:  gain_ang_i = $signed(val);
            ddpt_pkg::CFG_PWM_LIM: drive_limit = longint'(val[16:0]);
            ddpt_pkg::CFG_TAG_LIN: tag_gain_lin = $signed(val);
            ddpt_pkg::CFG_TAG_ANG: tag_gain_ang = $signed(val);
            default: begin
            end
        endcase
    endtask

    task automatic apply_setting(input bit m, input logic [31:0] lkp, input logic [31:0] lki,
                                 input logic [31:0] akp, input logic [31:0] aki,
                                 input logic [16:0] lim, input logic [31:0] tlg,
                                 input logic [31:0] tag);
        set_register(ddpt_pkg::CFG_MODE, {31'd0, m});
        set_register(ddpt_pkg::CFG_LIN_KP, lkp);
        set_register(ddpt_pkg::CFG_LIN_KI, lki);
        set_register(ddpt_pkg::CFG_ANG_KP, akp);
        set_register(ddpt_pkg::CFG_ANG_KI, aki);
        set_register(ddpt_pkg::CFG_PWM_LIM, {15'd0, lim});
        set_register(ddpt_pkg::CFG_TAG_LIN, tlg);
        set_register(ddpt_pkg::CFG_TAG_ANG, tag);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_quiet();
        do begin
            @(negedge aclk);
        end while (pending_words.size() != 0 || s_tvalid || drive_expected.size() != 0);
        repeat (24) @(posedge aclk);
    endtask

    function automatic ddpt_pkg::in_t vel_word(logic [31:0] lin, logic [31:0] ang,
                                               logic stop);
        ddpt_pkg::in_t w;
        w = '0;
        w.opcode = ddpt_pkg::OPC_VEL;
        w.cmd_lin = lin;
        w.cmd_ang = ang;
        w.stop_req = stop;
        return w;
    endfunction

    function automatic ddpt_pkg::in_t tag_word(logic [31:0] t, logic [31:0] ox,
                                               logic [31:0] oy, logic [31:0] gx,
                                               logic [31:0] gy);
        ddpt_pkg::in_t w;
        w = '0;
        w.opcode = ddpt_pkg::OPC_TAG;
        w.time_us = t;
        w.tag_off_x = ox;
        w.tag_off_y = oy;
        w.tag_goal_x = gx;
        w.tag_goal_y = gy;
        return w;
    endfunction

    function automatic ddpt_pkg::in_t tick_word(logic [31:0] t, logic [31:0] ml,
                                                logic [31:0] ma);
        ddpt_pkg::in_t w;
        w = '0;
        w.opcode = ddpt_pkg::OPC_TICK;
        w.time_us = t;
        w.meas_lin = ml;
        w.meas_ang = ma;
        return w;
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(15))
            0: return $urandom;
            1: return Q_MAX;
            2: return Q_MIN;
            3: return 32'(int'($urandom_range(4000)) - 2000);
            default: return 32'(int'($urandom_range(262143)) - 131072);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        return 32'(int'($urandom_range(131072)) - 65536);
    endfunction

    task automatic make_random(output ddpt_pkg::in_t w);
        int pick;
        case ($urandom_range(19))
            0: clock_us += $urandom_range(700000, 400000);
            1: clock_us = $urandom;
            default: clock_us += $urandom_range(60000);
        endcase
        pick = $urandom_range(99);
        w.opcode = (pick < 15) ? ddpt_pkg::OPC_VEL : (pick < 38) ? ddpt_pkg::OPC_TAG :
                   (pick < 93) ? ddpt_pkg::OPC_TICK : OPC_SPARE;
        w.time_us = clock_us;
        w.cmd_lin = rand_val();
        w.cmd_ang = rand_val();
        w.stop_req = ($urandom_range(99) < 15);
        w.tag_off_x = rand_val();
        w.tag_off_y = rand_val();
        w.tag_goal_x = rand_val();
        w.tag_goal_y = rand_val();
        if ($urandom_range(2) == 0) begin
            w.tag_goal_x = w.tag_off_x + 32'(int'($urandom_range(3000)) - 1500);
            w.tag_goal_y = w.tag_off_y + 32'(int'($urandom_range(3000)) - 1500);
        end
        w.meas_lin = rand_val();
        w.meas_ang = rand_val();
    endtask

    task automatic fill_random(input int count);
        ddpt_pkg::in_t w;
        int            counted;
        counted = 0;
        while (counted < count) begin
            make_random(w);
            pending_words.push_back(w);
            if (w.opcode != OPC_SPARE) counted++;
        end
    endtask

    initial begin
        ddpt_pkg::in_t spare;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 51;
        apply_setting(1'b1, 32'd65536, 32'd8192, 32'd65536, 32'd4096, 17'd65536,
                      32'd131072, 32'd196608);
        pending_words.push_back(tick_word(32'd500000, 32'd0, 32'd0));
        pending_words.push_back(tick_word(32'd500001, 32'd0, 32'd0));
        pending_words.push_back(tag_word(32'hFFFF_FF00, 32'd5000, -32'sd3000, 32'd1000, 32'd0));
        pending_words.push_back(tick_word(32'h0000_0100, 32'd1000, 32'd500));
        pending_words.push_back(tag_word(32'h200, 32'd1411, 32'd1310, 32'd100, 32'd0));
        pending_words.push_back(tick_word(32'h300, 32'd0, 32'd0));
        pending_words.push_back(tag_word(32'h400, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
        pending_words.push_back(tick_word(32'h500, Q_MIN, Q_MAX));
        pending_words.push_back(vel_word(Q_MAX, Q_MIN, 1'b0));
        pending_words.push_back(tick_word(32'h600, 32'd0, 32'd0));
        pending_words.push_back(vel_word(32'd0, 32'd0, 1'b1));
        pending_words.push_back(tick_word(32'h700, 32'd1000, 32'd1000));
        pending_words.push_back(tick_word(32'h700 + 32'd600000, 32'd0, 32'd0));
        spare = '1;
        spare.opcode = OPC_SPARE;
        pending_words.push_back(spare);
        pending_words.push_back(vel_word(32'd0, 32'd0, 1'b0));
        pending_words.push_back(tag_word(32'h100000, 32'd0, 32'd0, 32'd0, 32'd0));
        pending_words.push_back(tick_word(32'h100010, Q_MAX, Q_MIN));
        fill_random(150);
        wait_quiet();

        send_idle_pct = 51;
        recv_idle_pct = 19;
        apply_setting(1'b0, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 17'd65536, Q_MIN, Q_MAX);
        pending_words.push_back(vel_word(Q_MAX, Q_MIN, 1'b0));
        pending_words.push_back(tick_word(32'd0, Q_MIN, Q_MAX));
        pending_words.push_back(tick_word(32'd0, Q_MIN, Q_MAX));
        pending_words.push_back(tick_word(32'd0, Q_MAX, Q_MIN));
        pending_words.push_back(vel_word(32'd0, 32'd0, 1'b1));
        pending_words.push_back(tick_word(32'd0, 32'd7, 32'd9));
        fill_random(80);
        wait_quiet();

        apply_setting(1'b1, rand_gain(), rand_gain(), rand_gain(), rand_gain(), 17'd0,
                      Q_MAX, Q_MIN);
        fill_random(50);
        wait_quiet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(1'b0, rand_gain(), rand_gain(), rand_gain(), rand_gain(), 17'd32768,
                      rand_gain(), rand_gain());
        hold_requests++;
        fill_random(130);
        wait_quiet();

        apply_setting(1'b1, rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                      17'($urandom_range(65536, 1)),
                      32'(int'($urandom_range(524288)) - 262144),
                      32'(int'($urandom_range(524288)) - 262144));
        hold_requests++;
        fill_random(140);
        wait_quiet();

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
